// ===== design/cfspp_pkg.sv =====
package cfspp_pkg;

	// Parser phases.
	typedef enum logic [1:0] {
		PH_HDR1 = 2'd0,
		PH_HDR2 = 2'd1,
		PH_LEN  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CRC     = 2'd1,
		ST_BADHDR1 = 2'd2,
		ST_BADHDR2 = 2'd3
	} status_t;

	// Configuration register indexes.
	localparam logic CFG_FIRST_HEADER  = 1'b0;
	localparam logic CFG_SECOND_HEADER = 1'b1;

	localparam logic [7:0]  FIRST_HEADER_RST  = 8'hAA;
	localparam logic [7:0]  SECOND_HEADER_RST = 8'h55;
	localparam logic [15:0] CRC_POLY          = 16'h1021;
	localparam logic [23:0] OFFSET_BIT        = 24'h800000;
	localparam int          NUM_FIELD_BYTES   = 9;

	// One byte of CRC-16, MSB first, unrolled over the eight bits.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/crc_framed_sensor_packet_parser_unit.sv =====
// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------------------
// in       in_valid / in_ready    rx_byte
// out      out_valid / out_ready  status, gyro_rate, right_count, left_count,
//                                 good_frames, bad_events, frame_length
// cfg      cfg_we                 cfg_index, cfg_data
//
// One byte is accepted per cycle; its parse step, CRC update and field capture
// complete in the cycle of acceptance, and a result is registered for the next cycle.
// The result register is the only stall point: a new byte is taken whenever it
// is empty or being emptied in the same cycle.
// Asynchronous reset clears the parser, the captured values and the counters.
module crc_framed_sensor_packet_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [23:0] gyro_rate,
	output logic signed [23:0] right_count,
	output logic signed [23:0] left_count,
	output logic [31:0]        good_frames,
	output logic [31:0]        bad_events,
	output logic [7:0]         frame_length,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data
);
	import cfspp_pkg::*;

	logic [7:0]  first_header_q, second_header_q;
	phase_t      phase_q, phase_d;
	logic [8:0]  byte_index_q, byte_index_d;
	logic [7:0]  payload_length_q, payload_length_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_high_q, crc_high_d;
	logic [7:0]  fields_q [NUM_FIELD_BYTES];
	logic [7:0]  fields_d [NUM_FIELD_BYTES];
	logic [23:0] gyro_q, gyro_d, right_q, right_d, left_q, left_d;
	logic [31:0] good_q, good_d, bad_q, bad_d;
	logic        emit;
	status_t     status_d;
	logic [7:0]  frame_length_d;
	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  frame_length_q;
	logic        in_fire;
	logic [15:0] crc_upd;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign crc_upd  = crc_byte(crc_q, rx_byte);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_header_q  <= FIRST_HEADER_RST;
			second_header_q <= SECOND_HEADER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_HEADER:  first_header_q  <= cfg_data;
				CFG_SECOND_HEADER: second_header_q <= cfg_data;
				default:           first_header_q  <= first_header_q;
			endcase
		end
	end

	// Parse step for the byte at the input.
	always_comb begin
		phase_d          = phase_q;
		byte_index_d     = byte_index_q;
		payload_length_d = payload_length_q;
		crc_d            = crc_q;
		crc_high_d       = crc_high_q;
		fields_d         = fields_q;
		gyro_d           = gyro_q;
		right_d          = right_q;
		left_d           = left_q;
		good_d           = good_q;
		bad_d            = bad_q;
		emit             = 1'b0;
		status_d         = ST_OK;
		frame_length_d   = 8'd0;
		unique case (phase_q)
			PH_HDR1: begin
				if (rx_byte == first_header_q) begin
					crc_d   = crc_byte(16'h0000, rx_byte);
					phase_d = PH_HDR2;
				end else begin
					bad_d    = bad_q + 32'd1;
					emit     = 1'b1;
					status_d = ST_BADHDR1;
				end
			end
			PH_HDR2: begin
				if (rx_byte == second_header_q) begin
					crc_d   = crc_upd;
					phase_d = PH_LEN;
				end else begin
					bad_d    = bad_q + 32'd1;
					phase_d  = PH_HDR1;
					emit     = 1'b1;
					status_d = ST_BADHDR2;
				end
			end
			PH_LEN: begin
				crc_d            = crc_upd;
				payload_length_d = rx_byte;
				byte_index_d     = 9'd0;
				phase_d          = PH_DATA;
			end
			PH_DATA: begin
				// Frame bytes 3..11 land in the field store, CRC bytes included.
				for (int i = 0; i < NUM_FIELD_BYTES; i++) begin
					if (byte_index_q == 9'(i)) begin
						fields_d[i] = rx_byte;
					end
				end
				byte_index_d = byte_index_q + 9'd1;
				if (byte_index_q < {1'b0, payload_length_q}) begin
					crc_d = crc_upd;
				end else if (byte_index_q == {1'b0, payload_length_q}) begin
					crc_high_d = rx_byte;
				end else begin
					phase_d        = PH_HDR1;
					emit           = 1'b1;
					frame_length_d = payload_length_q;
					if ({crc_high_q, rx_byte} == crc_q) begin
						gyro_d   = {fields_d[0], fields_d[1], fields_d[2]};
						right_d  = {fields_d[3], fields_d[4], fields_d[5]} ^ OFFSET_BIT;
						left_d   = {fields_d[6], fields_d[7], fields_d[8]} ^ OFFSET_BIT;
						good_d   = good_q + 32'd1;
						status_d = ST_OK;
					end else begin
						bad_d    = bad_q + 32'd1;
						status_d = ST_CRC;
					end
				end
			end
			default: phase_d = PH_HDR1;
		endcase
	end

	// Parser state, captured values and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HDR1;
			byte_index_q     <= 9'd0;
			payload_length_q <= 8'd0;
			crc_q            <= 16'h0000;
			crc_high_q       <= 8'd0;
			for (int i = 0; i < NUM_FIELD_BYTES; i++) begin
				fields_q[i] <= 8'd0;
			end
			gyro_q  <= 24'd0;
			right_q <= 24'd0;
			left_q  <= 24'd0;
			good_q  <= 32'd0;
			bad_q   <= 32'd0;
		end else if (in_fire) begin
			phase_q          <= phase_d;
			byte_index_q     <= byte_index_d;
			payload_length_q <= payload_length_d;
			crc_q            <= crc_d;
			crc_high_q       <= crc_high_d;
			fields_q         <= fields_d;
			gyro_q           <= gyro_d;
			right_q          <= right_d;
			left_q           <= left_d;
			good_q           <= good_d;
			bad_q            <= bad_d;
		end
	end

	// Result register. Captured values and counters change only when a result
	// is loaded, so they drive the output payload directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			status_q       <= status_d;
			frame_length_q <= frame_length_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign frame_length = frame_length_q;
	assign gyro_rate    = gyro_q;
	assign right_count  = right_q;
	assign left_count   = left_q;
	assign good_frames  = good_q;
	assign bad_events   = bad_q;

	// The good frame counter moves only together with a frame-ok request.
	a_good_with_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(good_q != $past(good_q)) |-> (out_valid_q && status_q == ST_OK))
		else $error("good frame count changed without a frame-ok result");

	// The bad event counter moves only together with an error request.
	a_bad_with_err: assert property (@(posedge clk) disable iff (!arst_n)
		(bad_q != $past(bad_q)) |-> (out_valid_q && status_q != ST_OK))
		else $error("bad event count changed without an error result");

	// Inside a frame the byte position never runs past the second CRC byte.
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (byte_index_q <= ({1'b0, payload_length_q} + 9'd1)))
		else $error("byte position ran past the end of the frame");

endmodule

// ===== sim/packet_report_checker.sv =====
module packet_report_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic signed [23:0] gyro_rate,
	input  logic signed [23:0] right_count,
	input  logic signed [23:0] left_count,
	input  logic [31:0]        good_frames,
	input  logic [31:0]        bad_events,
	input  logic [7:0]         frame_length,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 mismatch_count,
	output int                 reports_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import cfspp_pkg::*;

	// One report that the parser is expected to send.
	typedef struct {
		status_t     status;
		logic [23:0] gyro;
		logic [23:0] right;
		logic [23:0] left;
		logic [31:0] good;
		logic [31:0] bad;
		logic [7:0]  length;
	} frame_report_t;

	frame_report_t pending_reports[$];

	// Shadow copy of the parser and its sync byte settings.
	logic [7:0]  sync_first = FIRST_HEADER_RST;
	logic [7:0]  sync_second = SECOND_HEADER_RST;
	phase_t      phase = PH_HDR1;
	logic [8:0]  position = '0;
	logic [7:0]  body_length = '0;
	logic [15:0] crc_sum = '0;
	logic [7:0]  crc_upper = '0;
	logic [7:0]  captured[NUM_FIELD_BYTES];
	logic [23:0] gyro_latch = '0;
	logic [23:0] right_latch = '0;
	logic [23:0] left_latch = '0;
	logic [31:0] good_total = '0;
	logic [31:0] bad_total = '0;

	initial begin
		mismatch_count = 0;
		reports_due = 0;
		foreach (captured[i]) captured[i] = '0;
	end

	// Bitwise CRC-16 update, one data bit per step, MSB first.
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
		logic feedback;
		for (int i = 7; i >= 0; i--) begin
			feedback = crc[15] ^ data[i];
			crc = {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	function automatic frame_report_t snapshot(input status_t code, input logic [7:0] length);
		frame_report_t r;
		r.status = code;
		r.gyro = gyro_latch;
		r.right = right_latch;
		r.left = left_latch;
		r.good = good_total;
		r.bad = bad_total;
		r.length = length;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t checker: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Advance the shadow parser by one received byte.
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [8:0] at;
		case (phase)
			PH_HDR1: begin
				if (b == sync_first) begin
					crc_sum = crc16_update(16'h0000, b);
					phase = PH_HDR2;
				end else begin
					bad_total++;
					pending_reports.push_back(snapshot(ST_BADHDR1, 8'd0));
				end
			end
			PH_HDR2: begin
				if (b == sync_second) begin
					crc_sum = crc16_update(crc_sum, b);
					phase = PH_LEN;
				end else begin
					// The failing byte is not tried again as a first sync byte.
					bad_total++;
					phase = PH_HDR1;
					pending_reports.push_back(snapshot(ST_BADHDR2, 8'd0));
				end
			end
			PH_LEN: begin
				crc_sum = crc16_update(crc_sum, b);
				body_length = b;
				position = '0;
				phase = PH_DATA;
			end
			default: begin
				at = position;
				if (at < NUM_FIELD_BYTES) captured[at] = b;
				position = at + 9'd1;
				if (at < body_length) begin
					crc_sum = crc16_update(crc_sum, b);
				end else if (at == body_length) begin
					crc_upper = b;
				end else begin
					phase = PH_HDR1;
					if ({crc_upper, b} == crc_sum) begin
						gyro_latch = {captured[0], captured[1], captured[2]};
						right_latch = {captured[3], captured[4], captured[5]} ^ OFFSET_BIT;
						left_latch = {captured[6], captured[7], captured[8]} ^ OFFSET_BIT;
						good_total++;
						pending_reports.push_back(snapshot(ST_OK, body_length));
					end else begin
						bad_total++;
						pending_reports.push_back(snapshot(ST_CRC, body_length));
					end
				end
			end
		endcase
	endtask

	// Compare every report against the oldest prediction, then track new requests.
	always @(posedge clk or negedge arst_n) begin
		frame_report_t want;
		if (!arst_n) begin
			sync_first = FIRST_HEADER_RST;
			sync_second = SECOND_HEADER_RST;
			phase = PH_HDR1;
			position = '0;
			body_length = '0;
			crc_sum = '0;
			crc_upper = '0;
			foreach (captured[i]) captured[i] = '0;
			gyro_latch = '0;
			right_latch = '0;
			left_latch = '0;
			good_total = '0;
			bad_total = '0;
			pending_reports.delete();
			reports_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					report("report with no prediction, status", 32'(status), 32'd0);
				end else begin
					want = pending_reports.pop_front();
					if (status !== want.status) begin
						report("status", 32'(status), 32'(want.status));
					end
					if (gyro_rate !== want.gyro) begin
						report("gyro_rate", 32'(unsigned'(gyro_rate)), 32'(want.gyro));
					end
					if (right_count !== want.right) begin
						report("right_count", 32'(unsigned'(right_count)), 32'(want.right));
					end
					if (left_count !== want.left) begin
						report("left_count", 32'(unsigned'(left_count)), 32'(want.left));
					end
					if (good_frames !== want.good) report("good_frames", good_frames, want.good);
					if (bad_events !== want.bad) report("bad_events", bad_events, want.bad);
					if (frame_length !== want.length) begin
						report("frame_length", 32'(frame_length), 32'(want.length));
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_FIRST_HEADER) sync_first = cfg_data;
				else sync_second = cfg_data;
			end
			if (in_valid && in_ready) parse_rx_byte(rx_byte);
			reports_due <= pending_reports.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cfspp_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [23:0] gyro_rate;
	logic signed [23:0] right_count;
	logic signed [23:0] left_count;
	logic [31:0]        good_frames;
	logic [31:0]        bad_events;
	logic [7:0]         frame_length;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_FIRST_HEADER;
	logic [7:0]         cfg_data = 8'h00;
	int                 mismatch_count;
	int                 reports_due;

	// Stimulus side copy of the sync bytes, plus the payload under construction.
	logic [7:0] sync_first = FIRST_HEADER_RST;
	logic [7:0] sync_second = SECOND_HEADER_RST;
	logic [7:0] frame_body[$];
	bit         stalls_on = 1'b1;
	int         bytes_sent = 0;

	crc_framed_sensor_packet_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.gyro_rate(gyro_rate),
		.right_count(right_count),
		.left_count(left_count),
		.good_frames(good_frames),
		.bad_events(bad_events),
		.frame_length(frame_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	packet_report_checker u_report_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.gyro_rate(gyro_rate),
		.right_count(right_count),
		.left_count(left_count),
		.good_frames(good_frames),
		.bad_events(bad_events),
		.frame_length(frame_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.reports_due(reports_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver holds off at random while stalls are enabled.
	always @(posedge clk) begin
		out_ready <= !stalls_on || ($urandom_range(99) >= 12);
	end

	// Shift-register CRC-16 used to build well-formed frames.
	function automatic logic [15:0] frame_crc_next(input logic [15:0] crc, input logic [7:0] data);
		crc = crc ^ {data, 8'h00};
		repeat (8) crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};
		return crc;
	endfunction

	// Offer one byte as a request and wait until the parser takes it.
	task automatic push_byte(input logic [7:0] value);
		if (stalls_on) begin
			while ($urandom_range(99) < 12) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		rx_byte <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic fill_body(input int length);
		frame_body.delete();
		repeat (length) frame_body.push_back(8'($urandom_range(255)));
	endtask

	// Place a 24-bit big-endian value at a payload position.
	task automatic put24(input int at, input logic [23:0] value);
		frame_body[at] = value[23:16];
		frame_body[at + 1] = value[15:8];
		frame_body[at + 2] = value[7:0];
	endtask

	// Send sync bytes, length, the current payload and its CRC, optionally corrupted.
	task automatic send_frame(input bit spoil_crc);
		logic [15:0] crc;
		logic [7:0]  low;
		crc = frame_crc_next(16'h0000, sync_first);
		crc = frame_crc_next(crc, sync_second);
		crc = frame_crc_next(crc, 8'(frame_body.size()));
		foreach (frame_body[i]) crc = frame_crc_next(crc, frame_body[i]);
		low = crc[7:0];
		if (spoil_crc) low = low ^ 8'($urandom_range(255, 1));
		push_byte(sync_first);
		push_byte(sync_second);
		push_byte(8'(frame_body.size()));
		foreach (frame_body[i]) push_byte(frame_body[i]);
		push_byte(crc[15:8]);
		push_byte(low);
	endtask

	// Hold back new requests until every predicted report has been delivered.
	task automatic drain_reports();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_header(input logic index, input logic [7:0] value);
		drain_reports();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_FIRST_HEADER) sync_first = value;
		else sync_second = value;
	endtask

	// Mostly well-formed frames with random content, plus broken sequences and noise.
	task automatic random_traffic(input int byte_budget);
		int target;
		int pick;
		target = bytes_sent + byte_budget;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				fill_body(($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(14));
				send_frame(pick >= 65);
			end else if (pick < 86) begin
				push_byte(sync_first);
				push_byte(sync_second ^ 8'($urandom_range(255, 1)));
			end else if (pick < 92) begin
				push_byte(sync_first ^ 8'($urandom_range(255, 1)));
			end else begin
				repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gyro and right encoder extremes in both directions, left encoder at its maximum and zero.
		fill_body(9);
		put24(0, 24'h800000);
		put24(3, 24'h000000);
		put24(6, 24'hFFFFFF);
		send_frame(1'b0);
		fill_body(12);
		put24(0, 24'h7FFFFF);
		put24(3, 24'hFFFFFF);
		put24(6, 24'h800000);
		send_frame(1'b0);

		// CRC failure, a bad first sync byte, and a bad second sync byte that
		// happens to match the first one.
		fill_body(9);
		send_frame(1'b1);
		push_byte(sync_first ^ 8'hFF);
		push_byte(sync_first);
		push_byte(sync_first);

		// Empty and short frames leave the CRC bytes in the field positions.
		fill_body(0);
		send_frame(1'b0);
		fill_body(3);
		send_frame(1'b0);

		// Longest frame, then the all-zero and all-one noise bytes.
		fill_body(255);
		send_frame(1'b0);
		push_byte(8'h00);
		push_byte(8'hFF);

		// Sync bytes at the extremes, first with no idling on either side and then with stalls, then random ones.
		write_header(CFG_FIRST_HEADER, 8'h00);
		write_header(CFG_SECOND_HEADER, 8'hFF);
		stalls_on = 1'b0;
		random_traffic(200);

		write_header(CFG_FIRST_HEADER, 8'hFF);
		write_header(CFG_SECOND_HEADER, 8'h00);
		stalls_on = 1'b1;
		random_traffic(170);

		write_header(CFG_FIRST_HEADER, 8'($urandom_range(255)));
		write_header(CFG_SECOND_HEADER, 8'($urandom_range(255)));
		random_traffic(170);

		// Identical sync bytes.
		write_header(CFG_FIRST_HEADER, 8'h3C);
		write_header(CFG_SECOND_HEADER, 8'h3C);
		random_traffic(140);

		drain_reports();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
